// File: rtl/shbh_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// shbh_pkg
// Shared constants, types and round functions of the SHA-256 byte stream
// hasher.
// ----------------------------------------------------------------------------
package shbh_pkg;

    localparam int BLOCK_BYTES = 64;
    localparam int BLOCK_BITS  = BLOCK_BYTES * 8;
    localparam int WORD_BITS   = 32;
    localparam int NUM_ROUNDS  = 64;
    localparam int HASH_WORDS  = 8;

    // byte position where the 64-bit length field starts
    localparam logic [5:0] LEN_POS    = 6'd56;
    localparam logic [5:0] LAST_POS   = 6'd63;
    localparam logic [7:0] PAD_MARK   = 8'h80;
    localparam logic [5:0] LAST_ROUND = 6'd63;
    localparam logic [2:0] LAST_WORD  = 3'd7;

    typedef logic [WORD_BITS-1:0] word_t;

    // working variables a..h, element 0 is a
    typedef logic [HASH_WORDS-1:0][WORD_BITS-1:0] work_vars_t;

    function automatic word_t big_sigma0(input word_t x);
        return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
    endfunction

    function automatic word_t big_sigma1(input word_t x);
        return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
    endfunction

    function automatic word_t small_sigma0(input word_t x);
        return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ (x >> 3);
    endfunction

    function automatic word_t small_sigma1(input word_t x);
        return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ (x >> 10);
    endfunction

    // initial hash value
    function automatic word_t init_hash(input logic [2:0] idx);
        word_t v;
        case (idx)
            3'd0:    v = 32'h6a09e667;
            3'd1:    v = 32'hbb67ae85;
            3'd2:    v = 32'h3c6ef372;
            3'd3:    v = 32'ha54ff53a;
            3'd4:    v = 32'h510e527f;
            3'd5:    v = 32'h9b05688c;
            3'd6:    v = 32'h1f83d9ab;
            default: v = 32'h5be0cd19;
        endcase
        return v;
    endfunction

    // round constants
    function automatic word_t round_const(input logic [5:0] idx);
        word_t v;
        case (idx)
            6'd0:  v = 32'h428a2f98;  6'd1:  v = 32'h71374491;
            6'd2:  v = 32'hb5c0fbcf;  6'd3:  v = 32'he9b5dba5;
            6'd4:  v = 32'h3956c25b;  6'd5:  v = 32'h59f111f1;
            6'd6:  v = 32'h923f82a4;  6'd7:  v = 32'hab1c5ed5;
            6'd8:  v = 32'hd807aa98;  6'd9:  v = 32'h12835b01;
            6'd10: v = 32'h243185be;  6'd11: v = 32'h550c7dc3;
            6'd12: v = 32'h72be5d74;  6'd13: v = 32'h80deb1fe;
            6'd14: v = 32'h9bdc06a7;  6'd15: v = 32'hc19bf174;
            6'd16: v = 32'he49b69c1;  6'd17: v = 32'hefbe4786;
            6'd18: v = 32'h0fc19dc6;  6'd19: v = 32'h240ca1cc;
            6'd20: v = 32'h2de92c6f;  6'd21: v = 32'h4a7484aa;
            6'd22: v = 32'h5cb0a9dc;  6'd23: v = 32'h76f988da;
            6'd24: v = 32'h983e5152;  6'd25: v = 32'ha831c66d;
            6'd26: v = 32'hb00327c8;  6'd27: v = 32'hbf597fc7;
            6'd28: v = 32'hc6e00bf3;  6'd29: v = 32'hd5a79147;
            6'd30: v = 32'h06ca6351;  6'd31: v = 32'h14292967;
            6'd32: v = 32'h27b70a85;  6'd33: v = 32'h2e1b2138;
            6'd34: v = 32'h4d2c6dfc;  6'd35: v = 32'h53380d13;
            6'd36: v = 32'h650a7354;  6'd37: v = 32'h766a0abb;
            6'd38: v = 32'h81c2c92e;  6'd39: v = 32'h92722c85;
            6'd40: v = 32'ha2bfe8a1;  6'd41: v = 32'ha81a664b;
            6'd42: v = 32'hc24b8b70;  6'd43: v = 32'hc76c51a3;
            6'd44: v = 32'hd192e819;  6'd45: v = 32'hd6990624;
            6'd46: v = 32'hf40e3585;  6'd47: v = 32'h106aa070;
            6'd48: v = 32'h19a4c116;  6'd49: v = 32'h1e376c08;
            6'd50: v = 32'h2748774c;  6'd51: v = 32'h34b0bcb5;
            6'd52: v = 32'h391c0cb3;  6'd53: v = 32'h4ed8aa4a;
            6'd54: v = 32'h5b9cca4f;  6'd55: v = 32'h682e6ff3;
            6'd56: v = 32'h748f82ee;  6'd57: v = 32'h78a5636f;
            6'd58: v = 32'h84c87814;  6'd59: v = 32'h8cc70208;
            6'd60: v = 32'h90befffa;  6'd61: v = 32'ha4506ceb;
            6'd62: v = 32'hbef9a3f7;  6'd63: v = 32'hc67178f2;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage
`default_nettype wire

// File: rtl/shbh_round.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// shbh_round
// One SHA-256 compression round plus one message schedule step, shared by
// all 64 rounds of a block.
// ----------------------------------------------------------------------------
module shbh_round
    import shbh_pkg::*;
(
    input  var work_vars_t vars_in,
    input  var word_t      w_t,     // schedule word of this round
    input  var word_t      w_t1,
    input  var word_t      w_t9,
    input  var word_t      w_t14,
    input  var word_t      k_t,
    output var work_vars_t vars_out,
    output var word_t      w_new    // schedule word sixteen rounds ahead
);

    word_t ch;
    word_t maj;
    word_t t1;
    word_t t2;

    // round function
    always_comb begin
        ch  = (vars_in[4] & vars_in[5]) ^ (~vars_in[4] & vars_in[6]);
        maj = (vars_in[0] & vars_in[1]) ^ (vars_in[0] & vars_in[2])
            ^ (vars_in[1] & vars_in[2]);
        t1  = vars_in[7] + big_sigma1(vars_in[4]) + ch + w_t + k_t;
        t2  = big_sigma0(vars_in[0]) + maj;
        vars_out[0] = t1 + t2;
        vars_out[1] = vars_in[0];
        vars_out[2] = vars_in[1];
        vars_out[3] = vars_in[2];
        vars_out[4] = vars_in[3] + t1;
        vars_out[5] = vars_in[4];
        vars_out[6] = vars_in[5];
        vars_out[7] = vars_in[6];
    end

    // message schedule expansion
    assign w_new = small_sigma1(w_t14) + w_t9 + small_sigma0(w_t1) + w_t;

endmodule
`default_nettype wire

// File: rtl/sha256_byte_stream_hasher.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sha256_byte_stream_hasher
// SHA-256 over a byte stream, at most one message byte per input transaction,
// eight digest words out per message.
// ----------------------------------------------------------------------------
// A byte transaction is taken whenever s_ready is high while the current
// 64-byte block fills. The byte that completes a block starts the
// compression: one round per cycle on a single shared round unit, 64 rounds
// and then a finish step that adds into the chaining value, with s_ready low
// throughout, so no byte is taken while a block is compressed. A transaction
// marked last then pads one byte per cycle (an extra padding block when the
// length field does not fit), runs the final compression(s) and presents the
// eight digest words, word 0 first, on the m_ channel, one per transaction.
// After word 7 is taken the block returns to its initial state and accepts
// the next message. A last transaction without a byte closes the message,
// so it also hashes an empty message.
// ----------------------------------------------------------------------------
module sha256_byte_stream_hasher
    import shbh_pkg::*;
(
    input  var logic        aclk,
    input  var logic        aresetn,
    input  var logic        s_valid,
    output var logic        s_ready,
    input  var logic [7:0]  s_msg_byte,
    input  var logic        s_byte_present,
    input  var logic        s_is_last,
    output var logic        m_valid,
    input  var logic        m_ready,
    output var logic [31:0] m_digest_word,
    output var logic [2:0]  m_word_index,
    output var logic        m_last_word
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PAD,
        ST_COMPRESS,
        ST_FINISH,
        ST_OUT
    } state_t;

    state_t                  state_reg, state_next;
    logic [BLOCK_BITS-1:0]   window_reg, window_next;
    logic [5:0]              fill_reg, fill_next;
    logic [60:0]             byte_count_reg, byte_count_next;
    word_t                   h_reg [HASH_WORDS];
    word_t                   h_next [HASH_WORDS];
    work_vars_t              vars_reg, vars_next;
    logic [5:0]              round_reg, round_next;
    logic [2:0]              out_idx_reg, out_idx_next;
    logic                    close_reg, close_next;
    logic                    mark_reg, mark_next;
    logic                    len_ok_reg, len_ok_next;
    logic                    final_reg, final_next;

    work_vars_t              vars_round;
    work_vars_t              h_packed;
    word_t                   w_new;
    logic [63:0]             bit_total;
    logic [2:0]              len_lane;
    logic [7:0]              len_byte;
    logic [7:0]              pad_byte;
    logic                    s_fire;
    logic                    m_fire;

    assign s_fire = s_valid & s_ready;
    assign m_fire = m_valid & m_ready;

    // shared round unit
    shbh_round u_round (
        .vars_in  (vars_reg),
        .w_t      (window_reg[BLOCK_BITS-1 -: WORD_BITS]),
        .w_t1     (window_reg[BLOCK_BITS-1*WORD_BITS-1 -: WORD_BITS]),
        .w_t9     (window_reg[BLOCK_BITS-9*WORD_BITS-1 -: WORD_BITS]),
        .w_t14    (window_reg[BLOCK_BITS-14*WORD_BITS-1 -: WORD_BITS]),
        .k_t      (round_const(round_reg)),
        .vars_out (vars_round),
        .w_new    (w_new)
    );

    // padding byte: marker, zeros, then big-endian bit length
    always_comb begin
        bit_total = {byte_count_reg, 3'b000};
        len_lane  = 3'd7 - fill_reg[2:0];
        len_byte  = 8'(bit_total >> {len_lane, 3'b000});
        if (!mark_reg) begin
            pad_byte = PAD_MARK;
        end else if ((fill_reg < LEN_POS) || !len_ok_reg) begin
            pad_byte = '0;
        end else begin
            pad_byte = len_byte;
        end
    end

    always_comb begin
        for (int i = 0; i < HASH_WORDS; i++) begin
            h_packed[i] = h_reg[i];
        end
    end

    // sequencer next state
    always_comb begin
        state_next      = state_reg;
        window_next     = window_reg;
        fill_next       = fill_reg;
        byte_count_next = byte_count_reg;
        round_next      = round_reg;
        out_idx_next    = out_idx_reg;
        close_next      = close_reg;
        mark_next       = mark_reg;
        len_ok_next     = len_ok_reg;
        final_next      = final_reg;
        vars_next       = h_packed;
        for (int i = 0; i < HASH_WORDS; i++) begin
            h_next[i] = h_reg[i];
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (s_fire) begin
                    if (s_byte_present) begin
                        window_next     = {window_reg[BLOCK_BITS-9:0], s_msg_byte};
                        fill_next       = fill_reg + 6'd1;
                        byte_count_next = byte_count_reg + 61'd1;
                    end
                    close_next = s_is_last;
                    if (s_byte_present && (fill_reg == LAST_POS)) begin
                        final_next = 1'b0;
                        state_next = ST_COMPRESS;
                    end else if (s_is_last) begin
                        state_next = ST_PAD;
                    end
                end
            end

            ST_PAD: begin
                window_next = {window_reg[BLOCK_BITS-9:0], pad_byte};
                fill_next   = fill_reg + 6'd1;
                if (!mark_reg) begin
                    mark_next   = 1'b1;
                    len_ok_next = (fill_reg < LEN_POS);
                end
                if (fill_reg == LAST_POS) begin
                    final_next = len_ok_reg;
                    state_next = ST_COMPRESS;
                end
            end

            ST_COMPRESS: begin
                vars_next   = vars_round;
                window_next = {window_reg[BLOCK_BITS-WORD_BITS-1:0], w_new};
                round_next  = round_reg + 6'd1;
                if (round_reg == LAST_ROUND) begin
                    state_next = ST_FINISH;
                end
            end

            ST_FINISH: begin
                for (int i = 0; i < HASH_WORDS; i++) begin
                    h_next[i] = h_reg[i] + vars_reg[i];
                end
                if (final_reg) begin
                    state_next = ST_OUT;
                end else if (close_reg) begin
                    if (mark_reg) begin
                        len_ok_next = 1'b1;
                    end
                    state_next = ST_PAD;
                end else begin
                    state_next = ST_IDLE;
                end
            end

            ST_OUT: begin
                if (m_fire) begin
                    out_idx_next = out_idx_reg + 3'd1;
                    if (out_idx_reg == LAST_WORD) begin
                        for (int i = 0; i < HASH_WORDS; i++) begin
                            h_next[i] = init_hash(3'(i));
                        end
                        byte_count_next = '0;
                        fill_next       = '0;
                        close_next      = 1'b0;
                        mark_next       = 1'b0;
                        len_ok_next     = 1'b0;
                        final_next      = 1'b0;
                        state_next      = ST_IDLE;
                    end
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // state, control and chaining value registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            fill_reg       <= '0;
            byte_count_reg <= '0;
            round_reg      <= '0;
            out_idx_reg    <= '0;
            close_reg      <= 1'b0;
            mark_reg       <= 1'b0;
            len_ok_reg     <= 1'b0;
            final_reg      <= 1'b0;
            for (int i = 0; i < HASH_WORDS; i++) begin
                h_reg[i] <= init_hash(3'(i));
            end
        end else begin
            state_reg      <= state_next;
            fill_reg       <= fill_next;
            byte_count_reg <= byte_count_next;
            round_reg      <= round_next;
            out_idx_reg    <= out_idx_next;
            close_reg      <= close_next;
            mark_reg       <= mark_next;
            len_ok_reg     <= len_ok_next;
            final_reg      <= final_next;
            for (int i = 0; i < HASH_WORDS; i++) begin
                h_reg[i] <= h_next[i];
            end
        end
    end

    // block data and working variables
    always_ff @(posedge aclk) begin
        window_reg <= window_next;
        vars_reg   <= vars_next;
    end

    // port drive
    assign s_ready       = (state_reg == ST_IDLE);
    assign m_valid       = (state_reg == ST_OUT);
    assign m_digest_word = h_reg[out_idx_reg];
    assign m_word_index  = out_idx_reg;
    assign m_last_word   = (out_idx_reg == LAST_WORD);

    // checks
    a_last_blocks_input: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_fire && s_is_last) |=> !s_ready)
        else $error("input taken right after a closing transaction");

    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_ready && m_valid))
        else $error("input and digest channels active together");

    a_round_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != ST_COMPRESS) |-> (round_reg == '0))
        else $error("round counter not at zero outside compression");

    a_digest_aligned: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (fill_reg == '0))
        else $error("digest presented with a partial block buffered");

    a_return_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_fire && m_last_word) |=> (s_ready && (byte_count_reg == '0)))
        else $error("no return to initial state after final digest word");

endmodule
`default_nettype wire
